/* hw/rtl/lie_pkg.sv */
// Shared types and constants for the logical immediate encoder.
// No dependencies; used by lie_encode, logical_immediate_encoder and lie_checker.
package lie_pkg;

   // Seed ORed into the ones count less one before it is shifted per element size
   localparam logic [12:0] IMMS_SEED  = 13'h1780;
   // Keep the N bit and the six imms bits after shifting
   localparam logic [12:0] FIELD_MASK = 13'h103f;
   // Encoded word given for a constant that cannot be encoded
   localparam logic [31:0] FAIL_WORD  = 32'hffff_ffff;
   // Element sizes tried: 64, 32, 16, 8, 4, 2
   localparam int unsigned NUM_SIZES  = 6;

   // Request item: constant and operation width
   typedef struct packed {
      logic [63:0] value;
      logic        is_wide;
   } req_type;

   // Result item: encodable flag, placed word and the three fields
   typedef struct packed {
      logic        valid_res;
      logic [31:0] encoded_word;
      logic        n_bit;
      logic [5:0]  rotate_amount;
      logic [5:0]  size_and_ones;
   } rsp_type;

endpackage

/* hw/rtl/logical_immediate_encoder.sv */
// Top level of the logical (bitmask) immediate encoder.
// Depends on lie_pkg and lie_encode.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------
//   req     | in        | req_valid/ready    | lie_pkg::req_type (value, is_wide)
//   rsp     | out       | rsp_valid/ready    | lie_pkg::rsp_type (five result fields)
//
// One item per cycle while rsp is not stalled; a request passes the input register,
// encode logic and result register before rsp_valid shows its result.
// Reset clears both valid flags; no clearing pass is needed.
// A stalled result holds in the result register while the input register can
// still take one more item; req_ready drops only when both are full and rsp
// is stalled.
module logical_immediate_encoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lie_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lie_pkg::rsp_type rsp_data
);

   logic             in_valid_ff, in_valid_in;
   lie_pkg::req_type in_req_ff;
   logic             out_valid_ff, out_valid_in;
   lie_pkg::rsp_type out_rsp_ff;
   lie_pkg::rsp_type enc_rsp;
   logic             out_free;
   logic             advance;
   logic             take;

   // Handshake: result register frees up when empty or taken
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign take      = req_valid && req_ready;

   assign in_valid_in  = take || (in_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   lie_encode u_encode (
      .req (in_req_ff),
      .rsp (enc_rsp)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload: load on acceptance, hold otherwise
   always_ff @(posedge clock) begin
      if (take) begin
         in_req_ff <= req_data;
      end
      if (advance) begin
         out_rsp_ff <= enc_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

endmodule

/* hw/rtl/lie_encode.sv */
// Combinational bitmask immediate encoder: one request item in, one result out.
// Depends on lie_pkg for the item types and field constants.
module lie_encode (
   input  lie_pkg::req_type req,
   output lie_pkg::rsp_type rsp
);

   // Count leading zeros of one byte (8 when zero)
   function automatic logic [3:0] clz8(input logic [7:0] b);
      logic [3:0] n;
      logic       hit;
      n   = 4'd8;
      hit = 1'b0;
      for (int i = 7; i >= 0; i--) begin
         if (!hit && b[i]) begin
            n   = 4'(7 - i);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

   // Count leading zeros of a 64-bit word, byte by byte from the top (64 when zero)
   function automatic logic [6:0] clz64(input logic [63:0] w);
      logic [6:0] n;
      logic       hit;
      n   = 7'd64;
      hit = 1'b0;
      for (int k = 7; k >= 0; k--) begin
         if (!hit && (w[k*8 +: 8] != 8'd0)) begin
            n   = 7'(8 * (7 - k)) + {3'd0, clz8(w[k*8 +: 8])};
            hit = 1'b1;
         end
      end
      return n;
   endfunction

   // Reverse bit order so trailing zeros become leading zeros
   function automatic logic [63:0] rev64(input logic [63:0] w);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) begin
         r[i] = w[63 - i];
      end
      return r;
   endfunction

   // Count ones: per byte, then sum the eight byte counts
   function automatic logic [6:0] pop64(input logic [63:0] w);
      logic [6:0] sum;
      logic [3:0] part;
      sum = 7'd0;
      for (int k = 0; k < 8; k++) begin
         part = 4'd0;
         for (int i = 0; i < 8; i++) begin
            part = part + {3'd0, w[k*8 + i]};
         end
         sum = sum + {3'd0, part};
      end
      return sum;
   endfunction

   logic [63:0] v;
   logic [63:0] nv;
   logic        degenerate;
   logic [6:0]  lz, ilz, tz, itz, pop;
   logic [12:0] seed_or;
   logic [4:0]  halves_eq;
   logic [5:0]  hit_a, hit_b;
   logic [5:0]  rot [lie_pkg::NUM_SIZES];
   logic [12:0] field [lie_pkg::NUM_SIZES];
   logic        found;
   logic        alive;
   logic [5:0]  sel_rot;
   logic [12:0] sel_field;

   // Widen a 32-bit operand by ORing its low half into the upper half
   assign v          = req.is_wide ? req.value : (req.value | {req.value[31:0], 32'd0});
   assign nv         = ~v;
   assign degenerate = (v == 64'd0) || (nv == 64'd0);

   // Whole-word counts shared by every element size
   assign lz  = clz64(v);
   assign ilz = clz64(nv);
   assign tz  = clz64(rev64(v));
   assign itz = clz64(rev64(nv));
   assign pop = pop64(v);

   assign seed_or = lie_pkg::IMMS_SEED | {6'd0, pop - 7'd1};

   // Check, per element size, for a plain or a wrapped run and the two halves
   always_comb begin
      logic [7:0] size;
      logic [7:0] epop;
      logic [63:0] mask;
      int unsigned half;
      for (int e = 0; e < lie_pkg::NUM_SIZES; e++) begin
         size     = 8'(64 >> e);
         epop     = {1'b0, pop >> e};
         hit_a[e] = (({1'b0, lz} + {1'b0, tz}) == (size - epop));
         hit_b[e] = (({1'b0, ilz} + {1'b0, itz}) == epop);
         if (hit_a[e]) begin
            rot[e] = (tz != 7'd0) ? 6'(size - {1'b0, tz}) : 6'd0;
         end else begin
            rot[e] = ilz[5:0];
         end
         field[e] = (seed_or >> e) & lie_pkg::FIELD_MASK;
      end
      for (int e = 0; e < lie_pkg::NUM_SIZES - 1; e++) begin
         half         = 32 >> e;
         mask         = (64'd1 << half) - 64'd1;
         halves_eq[e] = (((v ^ (v >> half)) & mask) == 64'd0);
      end
   end

   // Take the largest size that matches, stopping where the halves differ
   always_comb begin
      found     = 1'b0;
      alive     = !degenerate;
      sel_rot   = 6'd0;
      sel_field = 13'd0;
      for (int e = 0; e < lie_pkg::NUM_SIZES; e++) begin
         if (alive) begin
            if (hit_a[e] || hit_b[e]) begin
               found     = 1'b1;
               alive     = 1'b0;
               sel_rot   = rot[e];
               sel_field = field[e];
            end else if (e < lie_pkg::NUM_SIZES - 1) begin
               if (!halves_eq[e]) begin
                  alive = 1'b0;
               end
            end
         end
      end
   end

   // Place the fields, or give the failure pattern
   always_comb begin
      if (found) begin
         rsp.valid_res     = 1'b1;
         rsp.encoded_word  = {9'd0, sel_field[12], sel_rot, sel_field[5:0], 10'd0};
         rsp.n_bit         = sel_field[12];
         rsp.rotate_amount = sel_rot;
         rsp.size_and_ones = sel_field[5:0];
      end else begin
         rsp.valid_res     = 1'b0;
         rsp.encoded_word  = lie_pkg::FAIL_WORD;
         rsp.n_bit         = 1'b0;
         rsp.rotate_amount = 6'd0;
         rsp.size_and_ones = 6'd0;
      end
   end

endmodule

/* hw/rtl/lie_checker.sv */
// Port-level checks for logical_immediate_encoder, attached by bind.
// Depends on lie_pkg for the item types and the failure word.
module lie_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input lie_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input lie_pkg::rsp_type rsp_data
);

   // Failure items carry the all-ones word and zero fields
   a_fail_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.valid_res) |->
         (rsp_data.encoded_word == lie_pkg::FAIL_WORD) && !rsp_data.n_bit &&
         (rsp_data.rotate_amount == 6'd0) && (rsp_data.size_and_ones == 6'd0))
      else $error("failure item has wrong field values");

   // Encoded word matches its fields
   a_word_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.valid_res) |->
         (rsp_data.encoded_word == {9'd0, rsp_data.n_bit, rsp_data.rotate_amount,
                                    rsp_data.size_and_ones, 10'd0}))
      else $error("encoded word disagrees with its fields");

   // An empty result side never blocks new items
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low while no result is pending");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result item changed or dropped");

   // No result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind logical_immediate_encoder lie_checker u_lie_checker (.*);
